// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker modules of this block.
// Each macro clocks on the given clock and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define ASSERT_IMPLIES(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bmprs_pkg.sv =====
package bmprs_pkg;

    // Largest accepted image width and height.
    localparam int MAX_DIM = 100000;

    // Header layout, as byte offsets into the file.
    localparam logic [5:0] HDR_LAST   = 6'd53;
    localparam logic [5:0] OFF_WIDTH  = 6'd18;
    localparam logic [5:0] OFF_HEIGHT = 6'd22;
    localparam logic [5:0] OFF_DEPTH  = 6'd28;

    // File mark and the only accepted pixel depth.
    localparam logic [7:0]  MARK_B      = 8'h42;
    localparam logic [7:0]  MARK_M      = 8'h4D;
    localparam logic [15:0] DEPTH_RGB24 = 16'd24;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_PIXEL     = 3'd0,
        KIND_HEADER    = 3'd1,
        KIND_FORMAT    = 3'd2,
        KIND_PREMATURE = 3'd3,
        KIND_COMPLETE  = 3'd4
    } kind_t;

    // One result item.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [16:0] column;
        logic [16:0] row;
        logic [16:0] width;
        logic [16:0] height;
        logic        last;
    } res_t;

    // Results of one processed byte, handed from the parser to the output queue.
    typedef struct packed {
        logic       en;
        logic [1:0] cnt;
        res_t       res0;
        res_t       res1;
    } push_t;

endpackage

// ===== hw/rtl/bmp_rgb24_stream_parser.sv =====
// Streaming reader for uncompressed 24-bit BMP files.
// The slave channel takes the file one byte per item, with tlast on the
// file's last byte. The master channel gives result items: the kind in
// tuser, pixel colour, position and image size in tdata, and tlast on the
// final result caused by one input byte.
// A byte is held in an input register and decoded once the queue has room,
// and its results (none, one or two) are written into a two-slot output
// queue. The first result reaches the master channel through the input
// register and then the queue's head slot, where it waits for tready.
// Throughput is one byte per cycle while the receiver keeps tready high;
// a byte that yields two results holds the decoder back, as the single
// output port drains the queue one result per cycle.
// Reset returns the parser to expecting a file header and empties the
// input register and the queue. When the receiver stalls, results wait in
// the queue, the decoder stops once the queue cannot take two more, and
// s_tready drops as soon as the input register is also full.
module bmp_rgb24_stream_parser
    import bmprs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte [7:0]
    input  logic        s_tlast,   // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // red, green, blue, column, row, width, height, zero fill
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast    // last
);

    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_eof_reg;
    logic       s_fire;
    logic       fire;
    logic       room;
    push_t      push;
    res_t       head;

    // Input register, refilled in the cycle its byte is decoded.
    assign fire     = in_vld_reg && room;
    assign s_tready = !in_vld_reg || fire;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_fire)
        begin
            in_vld_next = 1'b1;
        end
        else if (fire)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg <= s_tdata;
            in_eof_reg  <= s_tlast;
        end
    end

    // Header and pixel decoder.
    bmprs_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_byte (in_byte_reg),
        .in_eof  (in_eof_reg),
        .push    (push)
    );

    // Result queue in front of the master channel.
    bmprs_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .head_ready (m_tready),
        .room       (room),
        .head_valid (m_tvalid),
        .head       (head)
    );

    // Pack the head result onto the master channel.
    assign m_tdata = {4'd0, head.height, head.width, head.row, head.column,
                      head.blue, head.green, head.red};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

// ===== hw/rtl/bmprs_parser.sv =====
module bmprs_parser
    import bmprs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] in_byte,
    input  logic       in_eof,
    output push_t      push
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_PIXELS = 3'b010,
        PH_DRAIN  = 3'b100
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [5:0]  off_reg,    off_next;
    logic [31:0] width_reg,  width_next;
    logic [31:0] height_reg, height_next;
    logic [15:0] depth_reg,  depth_next;
    logic [7:0]  blue_reg,   blue_next;
    logic [7:0]  green_reg,  green_next;
    logic [1:0]  bip_reg,    bip_next;
    logic [16:0] col_reg,    col_next;
    logic [16:0] row_reg,    row_next;
    logic [1:0]  pad_reg,    pad_next;

    res_t        res [2];
    logic [1:0]  cnt;
    logic        end_row;
    logic [16:0] col_inc;
    logic [16:0] row_inc;
    logic [1:0]  pad_dec;
    logic [1:0]  lane;
    logic        hdr_ok;

    // Byte decode: next state and up to two results for the current byte.
    always_comb
    begin
        phase_next  = phase_reg;
        off_next    = off_reg;
        width_next  = width_reg;
        height_next = height_reg;
        depth_next  = depth_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;
        bip_next    = bip_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pad_next    = pad_reg;
        res[0]      = '0;
        res[1]      = '0;
        cnt         = 2'd0;
        end_row     = 1'b0;
        col_inc     = col_reg + 17'd1;
        row_inc     = row_reg + 17'd1;
        pad_dec     = pad_reg - 2'd1;
        lane        = 2'd0;
        hdr_ok      = (width_reg >= 32'd1) && (width_reg <= 32'(MAX_DIM)) &&
                      (height_reg >= 32'd1) && (height_reg <= 32'(MAX_DIM)) &&
                      (depth_reg == DEPTH_RGB24);

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (((off_reg == 6'd0) && (in_byte != MARK_B)) ||
                    ((off_reg == 6'd1) && (in_byte != MARK_M)))
                begin
                    res[0].kind = KIND_FORMAT;
                    cnt         = 2'd1;
                    phase_next  = PH_DRAIN;
                end
                else
                begin
                    // Little-endian size and depth fields, one byte lane at a time.
                    if ((off_reg >= OFF_WIDTH) && (off_reg < OFF_WIDTH + 6'd4))
                    begin
                        lane       = 2'(off_reg - OFF_WIDTH);
                        width_next = width_reg | (32'(in_byte) << {lane, 3'b000});
                    end
                    else if ((off_reg >= OFF_HEIGHT) && (off_reg < OFF_HEIGHT + 6'd4))
                    begin
                        lane        = 2'(off_reg - OFF_HEIGHT);
                        height_next = height_reg | (32'(in_byte) << {lane, 3'b000});
                    end
                    else if ((off_reg >= OFF_DEPTH) && (off_reg < OFF_DEPTH + 6'd2))
                    begin
                        lane       = 2'(off_reg - OFF_DEPTH);
                        depth_next = depth_reg | (16'(in_byte) << {lane[0], 3'b000});
                    end

                    if (off_reg != HDR_LAST)
                    begin
                        if (in_eof)
                        begin
                            res[0].kind = KIND_FORMAT;
                            cnt         = 2'd1;
                            phase_next  = PH_DRAIN;
                        end
                        else
                        begin
                            off_next = off_reg + 6'd1;
                        end
                    end
                    else if (hdr_ok)
                    begin
                        res[0].kind   = KIND_HEADER;
                        res[0].width  = width_reg[16:0];
                        res[0].height = height_reg[16:0];
                        cnt           = 2'd1;
                        phase_next    = PH_PIXELS;
                        bip_next      = 2'd0;
                        col_next      = '0;
                        row_next      = '0;
                        pad_next      = 2'd0;
                    end
                    else
                    begin
                        res[0].kind = KIND_FORMAT;
                        cnt         = 2'd1;
                        phase_next  = PH_DRAIN;
                    end
                end
            end
            PH_PIXELS:
            begin
                if (pad_reg != 2'd0)
                begin
                    // Row padding is consumed without a pixel result.
                    pad_next = pad_dec;
                    end_row  = (pad_dec == 2'd0);
                end
                else
                begin
                    unique case (bip_reg)
                        2'd0:
                        begin
                            blue_next = in_byte;
                            bip_next  = 2'd1;
                        end
                        2'd1:
                        begin
                            green_next = in_byte;
                            bip_next   = 2'd2;
                        end
                        default:
                        begin
                            bip_next      = 2'd0;
                            res[0].kind   = KIND_PIXEL;
                            res[0].red    = in_byte;
                            res[0].green  = green_reg;
                            res[0].blue   = blue_reg;
                            res[0].column = col_reg;
                            res[0].row    = row_reg;
                            cnt           = 2'd1;
                            if ({15'd0, col_inc} == width_reg)
                            begin
                                col_next = '0;
                                pad_next = width_reg[1:0];
                                end_row  = (width_reg[1:0] == 2'd0);
                            end
                            else
                            begin
                                col_next = col_inc;
                            end
                        end
                    endcase
                end

                // End of a row; the last row completes the image.
                if (end_row)
                begin
                    row_next = row_inc;
                    if ({15'd0, row_inc} == height_reg)
                    begin
                        res[cnt[0]]      = '0;
                        res[cnt[0]].kind = KIND_COMPLETE;
                        cnt              = cnt + 2'd1;
                        phase_next       = PH_DRAIN;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // A file that ends while pixels are still expected ends prematurely.
        if (in_eof && (phase_next == PH_PIXELS))
        begin
            res[cnt[0]]      = '0;
            res[cnt[0]].kind = KIND_PREMATURE;
            cnt              = cnt + 2'd1;
        end

        // The last byte of a file returns the parser to the header.
        if (in_eof)
        begin
            phase_next  = PH_HEADER;
            off_next    = '0;
            width_next  = '0;
            height_next = '0;
            depth_next  = '0;
            blue_next   = '0;
            green_next  = '0;
            bip_next    = '0;
            col_next    = '0;
            row_next    = '0;
            pad_next    = '0;
        end

        // Mark the final result of this byte.
        if (cnt == 2'd1)
        begin
            res[0].last = 1'b1;
        end
        else if (cnt == 2'd2)
        begin
            res[1].last = 1'b1;
        end
    end

    assign push.en   = fire;
    assign push.cnt  = cnt;
    assign push.res0 = res[0];
    assign push.res1 = res[1];

    // Parser state, updated once for each processed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            off_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            depth_reg  <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
            bip_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            pad_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            off_reg    <= off_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            depth_reg  <= depth_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            bip_reg    <= bip_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pad_reg    <= pad_next;
        end
    end

endmodule

// ===== hw/rtl/bmprs_out_queue.sv =====
module bmprs_out_queue
    import bmprs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    input  logic  head_ready,
    output logic  room,
    output logic  head_valid,
    output res_t  head
);

    logic [1:0] cnt_reg,   cnt_next;
    res_t       slot0_reg, slot0_next;
    res_t       slot1_reg, slot1_next;
    logic       pop;

    // A byte may be processed only when both slots are free after this cycle.
    assign pop        = (cnt_reg != 2'd0) && head_ready;
    assign room       = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = slot0_reg;

    // Load both slots on a push, otherwise shift up after a pop.
    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push.en)
        begin
            slot0_next = push.res0;
            slot1_next = push.res1;
            cnt_next   = push.cnt;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Result slots carry payload only.
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ===== hw/rtl/bmprs_checker.sv =====
`include "assert_macros.svh"

module bmprs_checker
    import bmprs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result item holds still.
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // An accepted header always reports a non-zero size.
    `ASSERT_IMPLIES(a_header_size, clk, rst_n, m_tvalid && (m_tuser == KIND_HEADER), (m_tdata[74:58] != 17'd0) && (m_tdata[91:75] != 17'd0), "header with zero size")

    // Status results carry no colour or position.
    `ASSERT_IMPLIES(a_status_clear, clk, rst_n, m_tvalid && (m_tuser != KIND_PIXEL), m_tdata[57:0] == 58'd0, "status result with pixel data")

    // A premature end is always the final result of its byte.
    `ASSERT_IMPLIES(a_premature_last, clk, rst_n, m_tvalid && (m_tuser == KIND_PREMATURE), m_tlast, "premature end not marked last")

endmodule

bind bmp_rgb24_stream_parser bmprs_checker u_checker (.*);
